[design/button_debounce_click_long_press_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce core
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_LONG_PRESS_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_LONG_PRESS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define BDCLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset.
`define BDCLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bdclp_pkg.sv]
// ----------------------------------------------------------------------------
// Button debounce package
// Types and constants shared by the button debounce core and its button unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bdclp_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RESET   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_MS_RESET = 16'd1000;

    typedef enum logic {
        CFG_DEBOUNCE_MS   = 1'b0,
        CFG_LONG_PRESS_MS = 1'b1
    } cfg_index_t;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_SEED   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESSED = 2'd1,
        EV_CLICKED = 2'd2,
        EV_LONG    = 2'd3
    } ev_t;

    typedef struct packed {
        logic              advance;
        logic              seed;
        logic              raw;
        logic [TIME_W-1:0] now;
    } btn_in_t;

    typedef struct packed {
        ev_t  ev;
        logic down;
    } btn_out_t;

endpackage

`default_nettype wire

[design/button_debounce_click_long_press_core.sv]
// An accepted item passes through the input register and then the result register.
// One item per cycle unless the output stalls; the per-button state update is a read-modify-write.
// The input register accepts a new item while a finished result waits on the output side.
// Reset clears the button state and valid flags and loads the default debounce and hold times.
// ----------------------------------------------------------------------------
// Two-button debounce core
// Debounces two buttons and reports press, click and long-press events per poll.
// ----------------------------------------------------------------------------
`default_nettype none
`include "button_debounce_click_long_press_core_defines.svh"

module button_debounce_click_long_press_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [bdclp_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_ms [31:0], raw_a_down [32], raw_b_down [33], zero [39:34]
    input  wire logic [39:0]                    s_axis_tdata,
    // cmd [0]
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // event_a [1:0], event_b [3:2], down_a [4], down_b [5], zero [7:6]
    output logic [7:0]                          m_axis_tdata
);

    logic [bdclp_pkg::CFG_W-1:0]    debounce_ms_reg;
    logic [bdclp_pkg::CFG_W-1:0]    long_press_ms_reg;

    logic                           in_valid_reg;
    logic                           cmd_reg;
    logic [bdclp_pkg::TIME_W-1:0]   now_reg;
    logic                           raw_a_reg;
    logic                           raw_b_reg;

    logic                           out_valid_reg;
    logic [7:0]                     out_data_reg;

    logic                           advance;
    logic                           in_take;
    bdclp_pkg::btn_in_t             ctl_a;
    bdclp_pkg::btn_in_t             ctl_b;
    bdclp_pkg::btn_out_t            res_a;
    bdclp_pkg::btn_out_t            res_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= bdclp_pkg::DEBOUNCE_MS_RESET;
            long_press_ms_reg <= bdclp_pkg::LONG_PRESS_MS_RESET;
        end
        else if (cfg_we)
        begin
            case (bdclp_pkg::cfg_index_t'(cfg_index))
                bdclp_pkg::CFG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_wdata;
                bdclp_pkg::CFG_LONG_PRESS_MS: long_press_ms_reg <= cfg_wdata;
                default:                      ;
            endcase
        end
    end

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= s_axis_tuser;
            now_reg   <= s_axis_tdata[31:0];
            raw_a_reg <= s_axis_tdata[32];
            raw_b_reg <= s_axis_tdata[33];
        end
    end

    assign ctl_a.advance = advance;
    assign ctl_a.seed    = (bdclp_pkg::cmd_t'(cmd_reg) == bdclp_pkg::CMD_SEED);
    assign ctl_a.raw     = raw_a_reg;
    assign ctl_a.now     = now_reg;

    assign ctl_b.advance = advance;
    assign ctl_b.seed    = (bdclp_pkg::cmd_t'(cmd_reg) == bdclp_pkg::CMD_SEED);
    assign ctl_b.raw     = raw_b_reg;
    assign ctl_b.now     = now_reg;

    bdclp_button u_button_a
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .debounce_ms   (debounce_ms_reg),
        .long_press_ms (long_press_ms_reg),
        .ctl           (ctl_a),
        .res           (res_a)
    );

    bdclp_button u_button_b
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .debounce_ms   (debounce_ms_reg),
        .long_press_ms (long_press_ms_reg),
        .ctl           (ctl_b),
        .res           (res_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {2'b00, res_b.down, res_a.down, res_b.ev, res_a.ev};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `BDCLP_ASSERT_NEXT(a_result_follows, advance, m_axis_tvalid, "processed item did not produce a result")
    `BDCLP_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg && $stable(now_reg) && $stable(cmd_reg), "stalled input item was lost or changed")
    `BDCLP_ASSERT_NOW(a_press_level, m_axis_tvalid && (m_axis_tdata[1:0] == bdclp_pkg::EV_PRESSED), m_axis_tdata[4], "press event on button A without a pressed level")
    `BDCLP_ASSERT_NOW(a_release_level, m_axis_tvalid && ((m_axis_tdata[3:2] == bdclp_pkg::EV_CLICKED) || (m_axis_tdata[3:2] == bdclp_pkg::EV_LONG)), !m_axis_tdata[5], "release event on button B with a pressed level")

endmodule

`default_nettype wire

[design/bdclp_button.sv]
// ----------------------------------------------------------------------------
// Button debounce unit
// Holds the debounce state of one button and works out its event for a poll.
// ----------------------------------------------------------------------------
`default_nettype none

module bdclp_button
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [bdclp_pkg::CFG_W-1:0]    debounce_ms,
    input  wire logic [bdclp_pkg::CFG_W-1:0]    long_press_ms,
    input  wire bdclp_pkg::btn_in_t             ctl,
    output bdclp_pkg::btn_out_t                 res
);

    logic                           stable_reg;
    logic                           stable_next;
    logic                           pending_reg;
    logic                           pending_next;
    logic                           long_hold_reg;
    logic                           long_hold_next;
    logic [bdclp_pkg::TIME_W-1:0]   change_time_reg;
    logic [bdclp_pkg::TIME_W-1:0]   change_time_next;
    logic [bdclp_pkg::TIME_W-1:0]   press_time_reg;
    logic [bdclp_pkg::TIME_W-1:0]   press_time_next;

    logic                           level_new;
    logic [bdclp_pkg::TIME_W-1:0]   since_change;
    logic [bdclp_pkg::TIME_W-1:0]   held_for;
    logic                           settled;
    logic                           held_long;
    bdclp_pkg::ev_t                 ev;

    assign level_new    = (ctl.raw != pending_reg);
    assign since_change = level_new ? '0 : (ctl.now - change_time_reg);
    assign held_for     = ctl.now - press_time_reg;
    assign settled      = (since_change >= {{(bdclp_pkg::TIME_W-bdclp_pkg::CFG_W){1'b0}},
                                            debounce_ms});
    assign held_long    = (held_for >= {{(bdclp_pkg::TIME_W-bdclp_pkg::CFG_W){1'b0}},
                                        long_press_ms});

    always_comb
    begin
        stable_next      = stable_reg;
        pending_next     = pending_reg;
        long_hold_next   = long_hold_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        ev               = bdclp_pkg::EV_NONE;
        if (ctl.seed)
        begin
            stable_next      = ctl.raw;
            pending_next     = ctl.raw;
            long_hold_next   = 1'b0;
            change_time_next = ctl.now;
            press_time_next  = ctl.now;
        end
        else if (ctl.raw != stable_reg)
        begin
            if (level_new)
            begin
                change_time_next = ctl.now;
                pending_next     = ctl.raw;
            end
            if (settled)
            begin
                // The pending level takes the old debounced level on acceptance.
                pending_next = stable_reg;
                stable_next  = ctl.raw;
                if (ctl.raw)
                begin
                    press_time_next = ctl.now;
                    long_hold_next  = 1'b0;
                    ev              = bdclp_pkg::EV_PRESSED;
                end
                else if (long_hold_reg || held_long)
                begin
                    ev = bdclp_pkg::EV_LONG;
                end
                else
                begin
                    ev = bdclp_pkg::EV_CLICKED;
                end
            end
        end
        else if (stable_reg && !long_hold_reg && held_long)
        begin
            long_hold_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            long_hold_reg   <= 1'b0;
            change_time_reg <= '0;
            press_time_reg  <= '0;
        end
        else if (ctl.advance)
        begin
            stable_reg      <= stable_next;
            pending_reg     <= pending_next;
            long_hold_reg   <= long_hold_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

    assign res.ev   = ev;
    assign res.down = stable_next;

endmodule

`default_nettype wire

[bench/tb_button_debounce_click_long_press_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the two-button debounce core
// Streams timestamped polls into the core, predicts each result with a model
// of the per-button debounce state, and checks every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_button_debounce_click_long_press_core;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTED = 10;

    typedef struct {
        bdclp_pkg::cmd_t cmd;
        logic [31:0]     now;
        logic            raw_a;
        logic            raw_b;
    } poll_t;

    typedef struct {
        bdclp_pkg::ev_t ev_a;
        bdclp_pkg::ev_t ev_b;
        logic           down_a;
        logic           down_b;
    } poll_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic                           cfg_index = bdclp_pkg::CFG_DEBOUNCE_MS;
    logic [bdclp_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [39:0]                    s_axis_tdata = '0;
    logic                           s_axis_tuser = bdclp_pkg::CMD_UPDATE;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [7:0]                     m_axis_tdata;

    // Predicted button state and register copies.
    logic                           stable_q  [2] = '{1'b0, 1'b0};
    logic                           pending_q [2] = '{1'b0, 1'b0};
    logic                           marked_q  [2] = '{1'b0, 1'b0};
    logic [bdclp_pkg::TIME_W-1:0]   change_q  [2] = '{32'd0, 32'd0};
    logic [bdclp_pkg::TIME_W-1:0]   press_q   [2] = '{32'd0, 32'd0};
    logic [bdclp_pkg::CFG_W-1:0]    debounce_cfg   = bdclp_pkg::DEBOUNCE_MS_RESET;
    logic [bdclp_pkg::CFG_W-1:0]    long_press_cfg = bdclp_pkg::LONG_PRESS_MS_RESET;

    poll_t                          pending_polls [$];
    poll_result_t                   expected_results [$];

    int                             polls_accepted = 0;
    int                             results_seen = 0;
    int                             mismatch_cnt = 0;
    int                             cycle_cnt = 0;
    int                             gap_left = 0;
    int                             stall_left = 0;
    int                             hold_left = 0;
    bit                             hold_done = 1'b0;
    logic                           hold_off = 1'b0;
    bit                             calm = 1'b0;

    logic [31:0]                    t_ms = 32'd0;
    logic                           level_a = 1'b0;
    logic                           level_b = 1'b0;

    button_debounce_click_long_press_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bdclp_pkg::ev_t debounce_button(int b, logic raw,
                                                       logic [31:0] now);
        bdclp_pkg::ev_t ev;
        ev = bdclp_pkg::EV_NONE;
        if (raw != stable_q[b])
        begin
            if (raw != pending_q[b])
            begin
                change_q[b]  = now;
                pending_q[b] = raw;
            end
            if (32'(now - change_q[b]) >= 32'(debounce_cfg))
            begin
                pending_q[b] = stable_q[b];
                stable_q[b]  = raw;
                if (raw)
                begin
                    press_q[b]  = now;
                    marked_q[b] = 1'b0;
                    ev = bdclp_pkg::EV_PRESSED;
                end
                else if (marked_q[b] ||
                         32'(now - press_q[b]) >= 32'(long_press_cfg))
                    ev = bdclp_pkg::EV_LONG;
                else
                    ev = bdclp_pkg::EV_CLICKED;
            end
        end
        else if (stable_q[b] && !marked_q[b])
        begin
            if (32'(now - press_q[b]) >= 32'(long_press_cfg))
                marked_q[b] = 1'b1;
        end
        return ev;
    endfunction

    function automatic poll_result_t debounce_poll(poll_t p);
        poll_result_t r;
        logic         raw [2];
        raw[0] = p.raw_a;
        raw[1] = p.raw_b;
        r.ev_a = bdclp_pkg::EV_NONE;
        r.ev_b = bdclp_pkg::EV_NONE;
        if (p.cmd == bdclp_pkg::CMD_SEED)
        begin
            for (int b = 0; b < 2; b++)
            begin
                stable_q[b]  = raw[b];
                pending_q[b] = raw[b];
                marked_q[b]  = 1'b0;
                change_q[b]  = p.now;
                press_q[b]   = p.now;
            end
        end
        else
        begin
            r.ev_a = debounce_button(0, raw[0], p.now);
            r.ev_b = debounce_button(1, raw[1], p.now);
        end
        r.down_a = stable_q[0];
        r.down_b = stable_q[1];
        return r;
    endfunction

    // Sender: presents queued polls and predicts the result of each accepted one.
    always @(posedge clk)
    begin
        poll_t p;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                p.cmd   = bdclp_pkg::cmd_t'(s_axis_tuser);
                p.now   = s_axis_tdata[31:0];
                p.raw_a = s_axis_tdata[32];
                p.raw_b = s_axis_tdata[33];
                expected_results.push_back(debounce_poll(p));
                polls_accepted <= polls_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_polls.size() > 0)
                begin
                    p = pending_polls.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'd0, p.raw_b, p.raw_a, p.now};
                    s_axis_tuser  <= p.cmd;
                    if (!calm && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(1, 11);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, after enough polls have gone in.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
        end
        else
        begin
            if (!hold_done && polls_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold_off <= 1'b1;
            end
            else
            begin
                hold_off <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts on top of the long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_off)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Checker: compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        poll_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTED)
                    $display("unexpected result %0d: tdata=%h", results_seen, m_axis_tdata);
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_axis_tdata[1:0] != e.ev_a || m_axis_tdata[3:2] != e.ev_b ||
                    m_axis_tdata[4] != e.down_a || m_axis_tdata[5] != e.down_b ||
                    m_axis_tdata[7:6] != 2'b00)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTED)
                        $display("result %0d: expected ev_a=%0d ev_b=%0d down_a=%b down_b=%b, %s",
                                 results_seen, e.ev_a, e.ev_b, e.down_a, e.down_b,
                                 $sformatf("got ev_a=%0d ev_b=%0d down_a=%b down_b=%b pad=%b",
                                           m_axis_tdata[1:0], m_axis_tdata[3:2],
                                           m_axis_tdata[4], m_axis_tdata[5],
                                           m_axis_tdata[7:6]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_button_debounce_click_long_press_core: errors");
            $finish;
        end
    end

    task automatic queue_poll(bdclp_pkg::cmd_t cmd, logic [31:0] now, logic a, logic b);
        poll_t p;
        p.cmd   = cmd;
        p.now   = now;
        p.raw_a = a;
        p.raw_b = b;
        pending_polls.push_back(p);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_polls.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(bdclp_pkg::cfg_index_t idx, logic [bdclp_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == bdclp_pkg::CFG_DEBOUNCE_MS)
            debounce_cfg = value;
        else
            long_press_cfg = value;
    endtask

    task automatic set_times(logic [bdclp_pkg::CFG_W-1:0] db,
                             logic [bdclp_pkg::CFG_W-1:0] lp);
        wait_idle();
        write_reg(bdclp_pkg::CFG_DEBOUNCE_MS, db);
        write_reg(bdclp_pkg::CFG_LONG_PRESS_MS, lp);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] next_step();
        logic [31:0] db;
        logic [31:0] lp;
        int          r;
        db = 32'(debounce_cfg);
        lp = 32'(long_press_cfg);
        r  = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, db + db / 2 + 1);
        else if (r < 85)
            return $urandom_range(0, lp + 1);
        else if (r < 97)
            return $urandom_range(0, 2 * (lp + db) + 2);
        else
            return $urandom();
    endfunction

    // Press and release sessions with bounce, plus occasional seeds and noise.
    task automatic random_phase(int n);
        logic a;
        logic b;
        int   r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            t_ms = t_ms + next_step();
            if (r < 4)
            begin
                level_a = 1'($urandom_range(0, 1));
                level_b = 1'($urandom_range(0, 1));
                queue_poll(bdclp_pkg::CMD_SEED, t_ms, level_a, level_b);
            end
            else if (r < 9)
            begin
                queue_poll(bdclp_pkg::CMD_UPDATE, $urandom(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                if ($urandom_range(0, 6) == 0)
                    level_a = ~level_a;
                if ($urandom_range(0, 6) == 0)
                    level_b = ~level_b;
                a = ($urandom_range(0, 9) == 0) ? ~level_a : level_a;
                b = ($urandom_range(0, 9) == 0) ? ~level_b : level_b;
                queue_poll(bdclp_pkg::CMD_UPDATE, t_ms, a, b);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default times: press, bounce, click, the pending-level quirk, long hold.
        queue_poll(bdclp_pkg::CMD_SEED,   32'd100,  1'b0, 1'b0);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd110,  1'b1, 1'b0);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd120,  1'b1, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd140,  1'b1, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd150,  1'b1, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd160,  1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd170,  1'b1, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd175,  1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd195,  1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd200,  1'b1, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd1200, 1'b1, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd1210, 1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd1250, 1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd1260, 1'b0, 1'b0);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd1300, 1'b0, 1'b0);
        // Timestamp wrap across a click.
        queue_poll(bdclp_pkg::CMD_SEED,   32'hFFFF_FFF0, 1'b1, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'h0000_0010, 1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'h0000_0030, 1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'h0000_0400, 1'b0, 1'b0);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'h0000_0430, 1'b0, 1'b0);

        // Zero debounce and zero hold: same-poll acceptance, every release long.
        set_times(16'd0, 16'd0);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd5000, 1'b1, 1'b0);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd5000, 1'b0, 1'b1);
        queue_poll(bdclp_pkg::CMD_UPDATE, 32'd5001, 1'b1, 1'b0);
        queue_poll(bdclp_pkg::CMD_SEED,   32'd5002, 1'b1, 1'b1);
        t_ms = 32'd6000;

        set_times(16'd3, 16'd40);
        random_phase(130);
        set_times(16'd65535, 16'd65535);
        random_phase(120);
        set_times(16'd0, 16'd0);
        random_phase(120);
        set_times(16'd10, 16'd200);
        random_phase(130);
        set_times(16'd1, 16'd15);
        calm = 1'b1;
        random_phase(130);

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("tb_button_debounce_click_long_press_core: clean");
        else
            $display("tb_button_debounce_click_long_press_core: errors");
        $finish;
    end

endmodule

`default_nettype wire
